### hdl/ibt_pkg.sv
`default_nettype none
package ibt_pkg;

    // Reservation request: half-open interval [start_time, end_time)
    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] end_time;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic [6:0] entries_used;
    } rsp_t;

    localparam logic [1:0] STATUS_BOOKED  = 2'd0;
    localparam logic [1:0] STATUS_OVERLAP = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;
    localparam logic [1:0] STATUS_INVALID = 2'd3;

endpackage
`default_nettype wire

### hdl/ibt_ram.sv
`default_nettype none
module ibt_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire ibt_pkg::req_t     wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output      ibt_pkg::req_t     rd_data
);

    ibt_pkg::req_t mem [DEPTH];
    ibt_pkg::req_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### hdl/interval_booking_table.sv
`default_nettype none
// Steps: an accepted request is answered after the scan reads each stored reservation,
// then the compare of the last read, the end check, the decide step and the response load;
// an empty table needs no reads. One request at a time: req_stall is high until the load,
// which waits while a previous response is stalled. An invalid range skips scan and decide.
// Reset: rst_n (async, active low) empties the table and drops any pending response;
// slot RAM contents are not cleared, only entries below the count are ever read.
module interval_booking_table #(
    parameter int CAPACITY = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output      logic          req_stall,
    input  wire ibt_pkg::req_t req,
    output      logic          rsp_valid,
    input  wire logic          rsp_stall,
    output      ibt_pkg::rsp_t rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    // Sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]       state_reg, state_next;
    ibt_pkg::req_t    hold_reg, hold_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             rvld_reg, rvld_next;
    logic             clash_reg, clash_next;
    logic [1:0]       status_reg, status_next;
    logic             out_vld_reg, out_vld_next;
    ibt_pkg::rsp_t    out_reg, out_next;

    logic             rd_en;
    logic             wr_en;
    ibt_pkg::req_t    rd_data;
    logic             overlap;
    logic [CNT_W+6:0] cnt_ext;

    // Slot RAM: one entry per stored reservation, appended at the count
    ibt_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (hold_reg),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    // Half-open intervals overlap when each starts before the other ends;
    // touching endpoints do not count.
    assign overlap = (hold_reg.start_time < rd_data.end_time) &&
                     (rd_data.start_time < hold_reg.end_time);

    // entries_used carries the low 7 bits of the count
    assign cnt_ext = {7'd0, count_reg};

    // Take a new request only while idle; the output register holds the
    // previous response independently.
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = out_vld_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next   = state_reg;
        hold_next    = hold_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        rvld_next    = rvld_reg;
        clash_next   = clash_reg;
        status_next  = status_reg;
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;

        // drop the response once the consumer takes it
        if (out_vld_reg && !rsp_stall)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    hold_next  = req;
                    clash_next = 1'b0;
                    idx_next   = '0;
                    rvld_next  = 1'b0;
                    if (req.start_time >= req.end_time)
                    begin
                        // empty or reversed range: skip the scan
                        status_next = ibt_pkg::STATUS_INVALID;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle, compare the data in the following cycle
                rvld_next = 1'b0;
                if (idx_reg < count_reg)
                begin
                    rd_en     = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                    rvld_next = 1'b1;
                end
                if (rvld_reg && overlap)
                begin
                    clash_next = 1'b1;
                end
                if ((idx_reg == count_reg) && !rvld_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                // overlap wins over full
                if (clash_reg)
                begin
                    status_next = ibt_pkg::STATUS_OVERLAP;
                end
                else if (count_reg == CAP_C)
                begin
                    status_next = ibt_pkg::STATUS_FULL;
                end
                else
                begin
                    wr_en       = 1'b1;
                    count_next  = count_reg + 1'b1;
                    status_next = ibt_pkg::STATUS_BOOKED;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_vld_reg || !rsp_stall)
                begin
                    out_next.status       = status_reg;
                    out_next.entries_used = cnt_ext[6:0];
                    out_vld_next          = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            rvld_reg    <= 1'b0;
            clash_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            rvld_reg    <= rvld_next;
            clash_reg   <= clash_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg   <= hold_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("reservation count exceeds capacity");

    a_write_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_DECIDE) && !clash_reg && (count_reg != CAP_C))
        else $error("slot write outside a clean booking");

    a_write_counts: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (count_reg == $past(count_reg) + 1'b1) &&
                  (status_reg == ibt_pkg::STATUS_BOOKED))
        else $error("booking did not advance the count");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg != ST_IDLE))
        else $error("accepted request left the sequencer idle");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (idx_reg < count_reg))
        else $error("scan read beyond stored entries");
`endif

endmodule
`default_nettype wire
